[src/brpa_pkg.sv]
// ----------------------------------------------------------------------------
// brpa_pkg
// shared widths, types and controller states of the bitmap run page allocator
// ----------------------------------------------------------------------------
package brpa_pkg;

  localparam int unsigned WORD_BITS     = 16;
  localparam int unsigned OFF_W         = 4;
  localparam int unsigned LEN_W         = 5;
  localparam int unsigned IDX_W         = 9;
  localparam int unsigned MAP_WORDS_DEF = 32;

  // run lengths outside 1..16 are rejected without a scan
  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WORD_BITS);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } brpa_state_e;

  // outcome of the search over one bitmap word
  typedef struct packed {
    logic                 hit;
    logic [OFF_W-1:0]     off;
    logic [WORD_BITS-1:0] bits;
  } brpa_fit_t;

endpackage

[src/brpa_if.sv]
// ----------------------------------------------------------------------------
// brpa_req_if / brpa_res_if
// valid/ready channels for allocation requests and their results
// ----------------------------------------------------------------------------
interface brpa_req_if;
  import brpa_pkg::*;

  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] run_length;

  modport source (output valid, output run_length, input ready);
  modport sink   (input valid, input run_length, output ready);
endinterface

interface brpa_res_if;
  import brpa_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] page_index;

  modport source (output valid, output found, output page_index, input ready);
  modport sink   (input valid, input found, input page_index, output ready);
endinterface

[src/brpa_run_finder.sv]
// ----------------------------------------------------------------------------
// brpa_run_finder
// finds the lowest offset in one bitmap word where a run of clear bits fits
// ----------------------------------------------------------------------------
module brpa_run_finder
  import brpa_pkg::*;
(
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [LEN_W-1:0]     run_length_i,
  output brpa_fit_t            fit_o
);

  logic [2*WORD_BITS-1:0] base_mask;
  logic [2*WORD_BITS-1:0] shifted;
  logic [LEN_W:0]         run_end;
  logic                   fits;

  assign base_mask = (32'(1) << run_length_i) - 32'(1);

  // walk from high to low so the lowest fitting offset wins
  always_comb begin
    fit_o = '0;
    for (int off = WORD_BITS - 1; off >= 0; off--) begin
      shifted = base_mask << off;
      run_end = (LEN_W + 1)'(off) + {1'b0, run_length_i};
      fits    = (run_end <= (LEN_W + 1)'(WORD_BITS)) &&
                ((word_i & shifted[WORD_BITS-1:0]) == '0);
      if (fits) begin
        fit_o.hit  = 1'b1;
        fit_o.off  = OFF_W'(off);
        fit_o.bits = word_i | shifted[WORD_BITS-1:0];
      end
    end
  end

endmodule

[src/bitmap_run_page_allocator_unit.sv]
// ----------------------------------------------------------------------------
// bitmap_run_page_allocator_unit
// first-fit allocator of page runs within 16-bit words of a page bitmap
// ----------------------------------------------------------------------------
// req_i carries run_length (1..16); res_o returns found and page_index, one
// result word per request, in request order. The bitmap sits in a single
// synchronous memory of MAP_WORDS x 16 bits, one read per cycle.
// After reset a clearing pass writes every word (word 0 gets page 0 marked
// as reserved); req_i is not ready until it ends. A request is scanned one
// bitmap word per cycle from word 0, stopping at the first hit or after the
// last word. An out of range run length completes without a scan, with
// found low. The matching run is written back in the cycle it is found, so
// the next request always sees it. A new request is not accepted until the
// current one is done.
// The result sits in an output register; a new request is accepted while it
// waits, and a finished result that cannot be placed holds the controller
// until res_o.ready frees the register.
// ----------------------------------------------------------------------------
module bitmap_run_page_allocator_unit
  import brpa_pkg::*;
#(
  parameter int unsigned MAP_WORDS = MAP_WORDS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  brpa_req_if.sink   req_i,
  brpa_res_if.source res_o
);

  localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned CW = $clog2(MAP_WORDS + 1);
  localparam int unsigned PW = AW + OFF_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

  logic [WORD_BITS-1:0] mem_q [MAP_WORDS];

  brpa_state_e state_q, state_d;
  logic [AW-1:0]        init_cnt_q, init_cnt_d;
  logic [CW-1:0]        rd_cnt_q, rd_cnt_d;
  logic                 chk_vld_q, chk_vld_d;
  logic [AW-1:0]        chk_addr_q;
  logic [WORD_BITS-1:0] rd_data_q;
  logic [LEN_W-1:0]     len_q, len_d;
  logic                 pend_found_q, pend_found_d;
  logic [IDX_W-1:0]     pend_idx_q, pend_idx_d;
  logic                 out_vld_q, out_vld_d;
  logic                 out_found_q;
  logic [IDX_W-1:0]     out_idx_q;
  logic                 out_load;

  logic                 rd_en;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [PW-1:0]        hit_page;
  brpa_fit_t            fit;

  brpa_run_finder u_finder (
    .word_i       (rd_data_q),
    .run_length_i (len_q),
    .fit_o        (fit)
  );

  assign hit_page = {chk_addr_q, fit.off};

  always_comb begin
    state_d      = state_q;
    init_cnt_d   = init_cnt_q;
    rd_cnt_d     = rd_cnt_q;
    chk_vld_d    = 1'b0;
    len_d        = len_q;
    pend_found_d = pend_found_q;
    pend_idx_d   = pend_idx_q;
    out_load     = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = chk_addr_q;
    wr_data      = fit.bits;
    req_i.ready  = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        wr_en      = 1'b1;
        wr_addr    = init_cnt_q;
        wr_data    = (init_cnt_q == '0) ? WORD_BITS'(1) : '0;
        init_cnt_d = init_cnt_q + AW'(1);
        if (init_cnt_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          len_d        = req_i.run_length;
          rd_cnt_d     = '0;
          pend_found_d = 1'b0;
          pend_idx_d   = '0;
          if (req_i.run_length < LEN_MIN || req_i.run_length > LEN_MAX) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // read of the next word overlaps the check of the previous one
        rd_en     = (rd_cnt_q < CW'(MAP_WORDS));
        chk_vld_d = rd_en;
        if (rd_en) begin
          rd_cnt_d = rd_cnt_q + CW'(1);
        end
        if (chk_vld_q) begin
          if (fit.hit) begin
            wr_en        = 1'b1;
            pend_found_d = 1'b1;
            pend_idx_d   = IDX_W'(hit_page);
            state_d      = ST_DONE;
          end else if (chk_addr_q == LAST_ADDR) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_vld_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase

    out_vld_d = out_load || (out_vld_q && !res_o.ready);
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.found      = out_found_q;
  assign res_o.page_index = out_idx_q;

  // bitmap memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q  <= mem_q[rd_cnt_q[AW-1:0]];
      chk_addr_q <= rd_cnt_q[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      init_cnt_q <= '0;
      rd_cnt_q   <= '0;
      chk_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      init_cnt_q <= init_cnt_d;
      rd_cnt_q   <= rd_cnt_d;
      chk_vld_q  <= chk_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q        <= len_d;
    pend_found_q <= pend_found_d;
    pend_idx_q   <= pend_idx_d;
    if (out_load) begin
      out_found_q <= pend_found_q;
      out_idx_q   <= pend_idx_q;
    end
  end

endmodule
